FILE: hdl/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

	localparam int CNT_W  = 32;
	localparam int CFG_W  = 24;
	localparam int POS_W  = 32;
	localparam int HDG_W  = 26;
	localparam int ANG_W  = 35;
	localparam int CXY_W  = 34;
	localparam int MUL_WA = 33;
	localparam int MUL_WB = 34;
	localparam int MUL_WP = MUL_WA + MUL_WB + 1;
	localparam int WIDE_W = 42;
	localparam int REM_W  = 26;
	localparam int ATAN_N = 24;
	localparam int IDX_W  = 5;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam logic [CFG_W-1:0] CPT_RST = 24'd1391146;
	localparam logic [CFG_W-1:0] DPC_RST = 24'd166886;

	localparam logic signed [CXY_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ANG_W-1:0] DEG90  = 35'sd1509949440;
	localparam logic signed [ANG_W-1:0] DEG180 = 35'sd3019898880;
	localparam logic signed [ANG_W-1:0] DEG360 = 35'sd6039797760;
	localparam logic [REM_W-1:0] FULL_TURN = 26'd23592960;

	typedef enum logic {
		REG_CPT = 1'b0,
		REG_DPC = 1'b1
	} reg_idx_t;

	// arctangent of 2^-i in Q.24 degrees
	function automatic logic signed [ANG_W-1:0] atan_deg(input logic [IDX_W-1:0] i);
		logic signed [ANG_W-1:0] r;
		case (i)
			5'd0:  r = 35'sd754974720;
			5'd1:  r = 35'sd445687602;
			5'd2:  r = 35'sd235489088;
			5'd3:  r = 35'sd119537938;
			5'd4:  r = 35'sd60000934;
			5'd5:  r = 35'sd30029717;
			5'd6:  r = 35'sd15018523;
			5'd7:  r = 35'sd7509720;
			5'd8:  r = 35'sd3754917;
			5'd9:  r = 35'sd1877466;
			5'd10: r = 35'sd938734;
			5'd11: r = 35'sd469367;
			5'd12: r = 35'sd234684;
			5'd13: r = 35'sd117342;
			5'd14: r = 35'sd58671;
			5'd15: r = 35'sd29335;
			5'd16: r = 35'sd14668;
			5'd17: r = 35'sd7334;
			5'd18: r = 35'sd3667;
			5'd19: r = 35'sd1833;
			5'd20: r = 35'sd917;
			5'd21: r = 35'sd458;
			5'd22: r = 35'sd229;
			5'd23: r = 35'sd115;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [MUL_WP-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/ddo_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module ddo_mul import ddo_pkg::*; #(
	parameter int WA = MUL_WA,
	parameter int WB = MUL_WB
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire  signed [WA-1:0]    a,
	input  wire  signed [WB-1:0]    b,
	output logic                    done,
	output logic signed [WA+WB:0]   p
);

	localparam int CW = $clog2(WB);

	logic signed [WA:0]   hi_q;
	logic [WB-1:0]        lo_q;
	logic signed [WA-1:0] a_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic signed [WA+1:0] addend;
	logic signed [WA+1:0] sum;
	logic                 last;

	assign last = (cnt_q == CW'(WB - 1));

	// one multiplier bit a cycle, the sign bit of b weighs negative
	always_comb begin
		addend = '0;
		if (lo_q[0]) begin
			addend = last ? -(WA+2)'(a_q) : (WA+2)'(a_q);
		end
		sum = (WA+2)'(hi_q) + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= b;
			a_q  <= a;
		end else if (busy_q) begin
			hi_q <= sum[WA+1:1];
			lo_q <= {sum[0], lo_q[WB-1:1]};
		end
	end

	assign done = done_q;
	assign p    = {hi_q, lo_q};

endmodule
`default_nettype wire

FILE: hdl/ddo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module ddo_cordic import ddo_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire  signed [ANG_W-1:0]   angle,
	output logic signed [CXY_W-1:0]   cos_v,
	output logic signed [CXY_W-1:0]   sin_v
);

	localparam int NSTEP = (STEPS > ATAN_N) ? ATAN_N : STEPS;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(NSTEP - 1);

	logic signed [ANG_W-1:0] a1, a2, a3, a4, z0;
	logic                    neg0;
	logic signed [CXY_W-1:0] x_q, y_q, xs, ys, xn, yn;
	logic signed [ANG_W-1:0] z_q, zn;
	logic [IDX_W-1:0]        cnt_q;
	logic                    run_q;
	logic                    neg_q;
	logic signed [CXY_W-1:0] cos_q, sin_q;

	// bring the angle to (-180,180], then fold into [-90,90]
	always_comb begin
		a1 = (angle > DEG180) ? angle - DEG360 : angle;
		a2 = (a1 > DEG180) ? a1 - DEG360 : a1;
		a3 = (a2 <= -DEG180) ? a2 + DEG360 : a2;
		a4 = (a3 <= -DEG180) ? a3 + DEG360 : a3;
		neg0 = 1'b0;
		z0 = a4;
		if (a4 > DEG90) begin
			z0 = a4 - DEG180;
			neg0 = 1'b1;
		end else if (a4 < -DEG90) begin
			z0 = a4 + DEG180;
			neg0 = 1'b1;
		end
	end

	always_comb begin
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		if (!z_q[ANG_W-1]) begin
			xn = x_q - ys;
			yn = y_q + xs;
			zn = z_q - atan_deg(cnt_q);
		end else begin
			xn = x_q + ys;
			yn = y_q - xs;
			zn = z_q + atan_deg(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= z0;
			neg_q <= neg0;
		end else if (run_q) begin
			x_q <= xn;
			y_q <= yn;
			z_q <= zn;
			if (cnt_q == LAST) begin
				cos_q <= neg_q ? -xn : xn;
				sin_q <= neg_q ? -yn : yn;
			end
		end
	end

	assign cos_v = cos_q;
	assign sin_v = sin_q;

endmodule
`default_nettype wire

FILE: hdl/differential_drive_odometry.sv
`timescale 1ns / 1ps
`default_nettype none
// Dead-reckoning odometry for a differential drive. Each input transaction carries absolute
// left and right encoder counts; one result transaction follows with the updated x and y
// position (Q16.16 cm, saturating) and heading (Q10.16 degrees, in (-360,360)). An accepted
// transaction goes through three passes of the bit-serial multipliers (two multipliers in
// parallel, CORDIC running alongside the first pass), a restoring modulo-360 reduction of
// the heading and, once the output is free, the load of the output register; then the next
// transaction can be taken.
// The next item is taken once the update is done, while the previous result may still wait
// at the output register.
module differential_drive_odometry import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     psel,
	input  wire                     penable,
	input  wire                     pwrite,
	input  wire  [2:0]              paddr,
	input  wire  [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire  signed [CNT_W-1:0] left_count,
	input  wire  signed [CNT_W-1:0] right_count,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [HDG_W-1:0] heading
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_DIV,
		S_FIN
	} state_t;

	localparam logic [5:0] DIV_LAST = 6'(WIDE_W - 1);

	state_t                  state_q;
	logic [CFG_W-1:0]        cpt_q, dpc_q;
	logic [CNT_W-1:0]        last_left_q, last_right_q;
	logic signed [HDG_W-1:0] heading_q;
	logic signed [POS_W-1:0] x_q, y_q;
	logic signed [MUL_WA-1:0] sum_q, dif_q;
	logic signed [POS_W-1:0] mean_q, diff_q;
	logic [WIDE_W-1:0]       mag_q;
	logic [REM_W-1:0]        rem_q;
	logic                    neg_q;
	logic [5:0]              cnt_q;
	logic                    go_q;
	logic                    out_valid_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q;
	logic signed [HDG_W-1:0] heading_out_q;

	logic                    accept, cfg_wr;
	logic signed [CNT_W-1:0] dl, dr;
	logic signed [ANG_W-1:0] angle;
	logic signed [CXY_W-1:0] cos_v, sin_v;
	logic signed [MUL_WA-1:0] a0, a1;
	logic signed [MUL_WB-1:0] b0, b1;
	logic signed [MUL_WP-1:0] p0, p1;
	logic                    done0, done1;
	logic signed [MUL_WP-1:0] rnd0, rnd1, wide_v;
	logic [REM_W:0]          r2;
	logic [REM_W-1:0]        rnext;
	logic                    out_free;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_CPT: prdata = 32'(cpt_q);
			REG_DPC: prdata = 32'(dpc_q);
			default: prdata = '0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign dl = left_count - last_left_q;
	assign dr = right_count - last_right_q;
	assign angle = {{(ANG_W-HDG_W-8){heading_q[HDG_W-1]}}, heading_q, 8'd0};

	// operands follow the pass the multipliers are started for
	always_comb begin
		case (state_q)
			S_MUL1: begin
				a0 = sum_q;
				b0 = MUL_WB'(cpt_q);
				a1 = dif_q;
				b1 = MUL_WB'(cpt_q);
			end
			S_MUL2: begin
				a0 = MUL_WA'(mean_q);
				b0 = cos_v;
				a1 = MUL_WA'(mean_q);
				b1 = sin_v;
			end
			default: begin
				a0 = MUL_WA'(diff_q);
				b0 = MUL_WB'(dpc_q);
				a1 = '0;
				b1 = '0;
			end
		endcase
	end

	ddo_mul #(.WA(MUL_WA), .WB(MUL_WB)) u_mul0 (
		.clk(clk), .arst_n(arst_n), .start(go_q), .a(a0), .b(b0), .done(done0), .p(p0)
	);

	ddo_mul #(.WA(MUL_WA), .WB(MUL_WB)) u_mul1 (
		.clk(clk), .arst_n(arst_n), .start(go_q), .a(a1), .b(b1), .done(done1), .p(p1)
	);

	ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(accept), .angle(angle),
		.cos_v(cos_v), .sin_v(sin_v)
	);

	always_comb begin
		rnd0 = '0;
		rnd1 = '0;
		case (state_q)
			S_MUL1: begin
				rnd0 = (p0 + 68'sd256) >>> 9;
				rnd1 = (p1 + 68'sd128) >>> 8;
			end
			S_MUL2: begin
				rnd0 = MUL_WP'(x_q) + ((p0 + 68'sd536870912) >>> 30);
				rnd1 = MUL_WP'(y_q) + ((p1 + 68'sd536870912) >>> 30);
			end
			default: begin
				rnd0 = (p0 + 68'sd32768) >>> 16;
			end
		endcase
		wide_v = MUL_WP'(heading_q) + rnd0;
		// restoring remainder step on the magnitude
		r2 = {rem_q, mag_q[WIDE_W-1]};
		rnext = (r2 >= (REM_W+1)'(FULL_TURN)) ? REM_W'(r2 - (REM_W+1)'(FULL_TURN))
			: r2[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cpt_q        <= CPT_RST;
			dpc_q        <= DPC_RST;
			last_left_q  <= '0;
			last_right_q <= '0;
			heading_q    <= '0;
			x_q          <= '0;
			y_q          <= '0;
			go_q         <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			go_q <= ((state_q == S_IDLE) && accept) ||
				(((state_q == S_MUL1) || (state_q == S_MUL2)) && done0 && done1);
			if (cfg_wr) begin
				case (reg_idx_t'(paddr[2]))
					REG_CPT: cpt_q <= pwdata[CFG_W-1:0];
					REG_DPC: dpc_q <= pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_left_q  <= left_count;
						last_right_q <= right_count;
						sum_q   <= MUL_WA'(dl) + MUL_WA'(dr);
						dif_q   <= MUL_WA'(dl) - MUL_WA'(dr);
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					if (done0 && done1) begin
						mean_q  <= sat32(rnd0);
						diff_q  <= sat32(rnd1);
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (done0 && done1) begin
						x_q     <= sat32(rnd0);
						y_q     <= sat32(rnd1);
						state_q <= S_MUL3;
					end
				end
				S_MUL3: begin
					if (done0) begin
						neg_q   <= wide_v[MUL_WP-1];
						mag_q   <= wide_v[MUL_WP-1] ? WIDE_W'(-wide_v) : WIDE_W'(wide_v);
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rnext;
					mag_q <= {mag_q[WIDE_W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						heading_q <= neg_q ? -HDG_W'(rnext) : HDG_W'(rnext);
						state_q   <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						pos_x_q       <= x_q;
						pos_y_q       <= y_q;
						heading_out_q <= heading_q;
						out_valid_q   <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign heading   = heading_out_q;

endmodule
`default_nettype wire

FILE: hdl/ddo_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module ddo_chk import ddo_pkg::*; (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     in_valid,
	input wire                     in_stall,
	input wire                     out_valid,
	input wire                     out_stall,
	input wire signed [POS_W-1:0]  pos_x,
	input wire signed [POS_W-1:0]  pos_y,
	input wire signed [HDG_W-1:0]  heading
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pos_x) && $stable(pos_y) && $stable(heading))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction taken during update");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading < 26'sd23592960) && (heading > -26'sd23592960))
		else $error("heading outside one turn");

endmodule

bind differential_drive_odometry ddo_chk u_ddo_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .pos_x(pos_x), .pos_y(pos_y),
	.heading(heading)
);
`default_nettype wire

FILE: tb/tb_differential_drive_odometry.sv
`timescale 1ns / 1ps
module tb_differential_drive_odometry;
	import ddo_pkg::*;

	typedef struct {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [HDG_W-1:0] h;
	} pose_t;

	typedef struct {
		logic [CNT_W-1:0] l;
		logic [CNT_W-1:0] r;
		bit               known;
		pose_t            p;
	} count_row_t;

	localparam int CYCLE_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CNT_W-1:0] left_count = '0, right_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [POS_W-1:0] pos_x, pos_y;
	logic signed [HDG_W-1:0] heading;

	differential_drive_odometry u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	longint unsigned cpt = CPT_RST, dpc = DPC_RST;
	logic [31:0] prev_l = '0, prev_r = '0;
	longint hdg_acc = 0, x_acc = 0, y_acc = 0;

	pose_t pose_q[$];
	int errors = 0;
	int idle_max = 6;
	int quiet_cycles = 0;

	function automatic longint rnd_shr(longint v, int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic pose_t odometry_step(logic [31:0] l, logic [31:0] r);
		logic [31:0] d;
		longint dl, dr, mean, diff, turn, a, cx, cy, z, xs, ys;
		bit flip;
		longint deg = 64'sd16777216;
		longint atan_q24[24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
			30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
			117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
		pose_t p;
		d = l - prev_l;
		dl = longint'($signed(d));
		d = r - prev_r;
		dr = longint'($signed(d));
		prev_l = l;
		prev_r = r;
		mean = clamp32(rnd_shr((dl + dr) * longint'(cpt), 9));
		diff = clamp32(rnd_shr((dl - dr) * longint'(cpt), 8));
		// cos/sin of the old heading, folded into [-90,90]
		a = hdg_acc * 256;
		flip = 1'b0;
		if (a > 180 * deg) a -= 360 * deg;
		if (a > 180 * deg) a -= 360 * deg;
		if (a <= -180 * deg) a += 360 * deg;
		if (a <= -180 * deg) a += 360 * deg;
		if (a > 90 * deg) begin
			a -= 180 * deg;
			flip = 1'b1;
		end else if (a < -90 * deg) begin
			a += 180 * deg;
			flip = 1'b1;
		end
		cx = 652032874;
		cy = 0;
		z = a;
		for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (z >= 0) begin
				cx -= ys;
				cy += xs;
				z -= atan_q24[i];
			end else begin
				cx += ys;
				cy -= xs;
				z += atan_q24[i];
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		x_acc = clamp32(x_acc + rnd_shr(mean * cx, 30));
		y_acc = clamp32(y_acc + rnd_shr(mean * cy, 30));
		turn = rnd_shr(diff * longint'(dpc), 16);
		hdg_acc = (hdg_acc + turn) % 64'sd23592960;
		p.x = x_acc[31:0];
		p.y = y_acc[31:0];
		p.h = hdg_acc[25:0];
		return p;
	endfunction

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(idx) << 2;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_CPT) cpt = val[23:0];
		else dpc = val[23:0];
	endtask

	// block must be idle before a register write
	task automatic drain_and_set(logic [23:0] c, logic [23:0] g);
		in_valid <= 1'b0;
		wait (pose_q.size() == 0);
		repeat (200) @(negedge clk);
		reg_write(REG_CPT, {8'h0, c});
		reg_write(REG_DPC, {8'h0, g});
	endtask

	task automatic send_counts(logic [31:0] l, logic [31:0] r, bit known, pose_t p);
		int gap;
		pose_t e;
		gap = $urandom_range(idle_max, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		left_count <= l;
		right_count <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		e = odometry_step(l, r);
		pose_q.push_back(known ? p : e);
		@(negedge clk);
	endtask

	task automatic random_phase(int n);
		logic [31:0] l, r;
		pose_t none;
		l = prev_l;
		r = prev_r;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(9, 0))
				0: begin
					l = $urandom;
					r = $urandom;
				end
				1: begin
					l = l + $urandom_range(32'h7fffffff, 32'h7fff0000);
					r = r - $urandom_range(32'h7fffffff, 32'h7fff0000);
				end
				default: begin
					l = l + $urandom_range(4000, 0) - 2000;
					r = r + $urandom_range(4000, 0) - 2000;
				end
			endcase
			send_counts(l, r, 1'b0, none);
		end
	endtask

	// transactions accepted on the result side are checked here
	always @(posedge clk) begin
		pose_t e;
		if (out_valid && !out_stall) begin
			if (pose_q.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d h=%0d", $time, pos_x, pos_y,
					heading);
				errors++;
			end else begin
				e = pose_q.pop_front();
				if (pos_x !== e.x) begin
					$display("%0t: pos_x expected %0d got %0d", $time, e.x, pos_x);
					errors++;
				end
				if (pos_y !== e.y) begin
					$display("%0t: pos_y expected %0d got %0d", $time, e.y, pos_y);
					errors++;
				end
				if (heading !== e.h) begin
					$display("%0t: heading expected %0d got %0d", $time, e.h, heading);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= CYCLE_LIMIT) begin
			$display("FAIL differential_drive_odometry");
			$finish;
		end
	end

	initial begin
		int n;
		@(negedge clk);
		forever begin
			n = $urandom_range(idle_max, 0);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	count_row_t rows[$];
	pose_t zero_pose = '{x: '0, y: '0, h: '0};

	initial begin
		pose_t none;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: a still item, then wrap and extreme counts
		rows = '{
			'{32'h0, 32'h0, 1'b1, zero_pose},
			'{32'd1000, 32'd1000, 1'b0, none},
			'{32'd1500, 32'd900, 1'b0, none},
			'{32'h7fffffff, 32'h7fffffff, 1'b0, none},
			'{32'h80000000, 32'h80000000, 1'b0, none},
			'{32'h80000000, 32'h7fffffff, 1'b0, none},
			'{32'hffffffff, 32'h00000001, 1'b0, none},
			'{32'h00000002, 32'hfffffffe, 1'b0, none}
		};
		foreach (rows[i]) send_counts(rows[i].l, rows[i].r, rows[i].known, rows[i].p);

		// largest scales: travel and position saturate
		drain_and_set(24'hffffff, 24'hffffff);
		rows = '{
			'{32'h7fffffff, 32'h7fffffff, 1'b0, none},
			'{32'hffffffff, 32'hffffffff, 1'b0, none},
			'{32'h7ffffffe, 32'h7ffffffe, 1'b0, none},
			'{32'h00000000, 32'h80000000, 1'b0, none},
			'{32'h80000000, 32'h00000000, 1'b0, none},
			'{32'h80001000, 32'h00000000, 1'b0, none}
		};
		foreach (rows[i]) send_counts(rows[i].l, rows[i].r, rows[i].known, rows[i].p);

		// one degree per cm, 1/256 cm per tick: a full turn lands on zero
		drain_and_set(24'd65536, 24'd65536);
		rows = '{
			'{prev_l + 32'd92160, prev_r, 1'b0, none},
			'{prev_l + 32'd46080, prev_r, 1'b0, none},
			'{prev_l, prev_r + 32'd138240, 1'b0, none}
		};
		foreach (rows[i]) send_counts(rows[i].l, rows[i].r, rows[i].known, rows[i].p);

		// zero scales: nothing moves
		drain_and_set(24'd0, 24'd0);
		send_counts(32'h12345678, 32'h87654321, 1'b0, none);
		send_counts(32'h0, 32'hffffffff, 1'b0, none);

		drain_and_set(CPT_RST, DPC_RST);
		idle_max = 0;
		random_phase(150);
		idle_max = 6;
		random_phase(400);
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: drain_and_set(24'hffffff, 24'hffffff);
				1: drain_and_set(24'd0, 24'hffffff);
				default: drain_and_set(24'($urandom), 24'($urandom));
			endcase
			random_phase(150);
		end

		in_valid <= 1'b0;
		wait (pose_q.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("PASS differential_drive_odometry");
		end else begin
			$display("FAIL differential_drive_odometry");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/ddo_pkg.sv
hdl/ddo_mul.sv
hdl/ddo_cordic.sv
hdl/differential_drive_odometry.sv
hdl/ddo_chk.sv
tb/tb_differential_drive_odometry.sv
